FILE: src/lfsr_noise_channel_with_envelope_assert.svh
// ----------------------------------------------------------------------------
// Noise voice assertion macros
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LFSR_NOISE_CHANNEL_WITH_ENVELOPE_ASSERT_SVH
`define LFSR_NOISE_CHANNEL_WITH_ENVELOPE_ASSERT_SVH

// same-cycle implication
`define LNCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LNCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lnce_pkg.sv
// ----------------------------------------------------------------------------
// Noise voice package
// Event codes, register indexes and widths shared by the noise voice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnce_pkg;

  localparam int unsigned LFSR_W   = 15;
  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned VOL_W    = 4;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ACT_W    = 3;

  localparam logic [LFSR_W-1:0] LFSR_RESET = LFSR_W'(1);
  localparam logic [VOL_W-1:0]  ENV_TOP    = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_QUARTER = 3'd1,
    ACT_HALF    = 3'd2,
    ACT_START   = 3'd3,
    ACT_DISABLE = 3'd4
  } action_t;

  localparam logic [IDX_W-1:0] REG_SHORT_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CONST_VOL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOLUME     = 3'd3;
  localparam logic [IDX_W-1:0] REG_HALT_LOOP  = 3'd4;

endpackage

FILE: src/lfsr_noise_channel_with_envelope.sv
// ----------------------------------------------------------------------------
// Noise voice with decay envelope
// Each result word is registered from its input word as that word is accepted.
// Throughput: one word per cycle unless a held result is stalled; the output register lets a new word in
// while the previous result is taken in the same cycle.
// Reset (synchronous, rst_n low): LFSR to 1, all other registers to 0 except level_r and active_r (not reset).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lfsr_noise_channel_with_envelope_assert.svh"

module lfsr_noise_channel_with_envelope
  import lnce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [LEN_W-1:0]    in_length_load,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VOL_W-1:0]    out_level,
  output logic                out_length_active,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  logic                short_mode_r, const_vol_r, halt_loop_r;
  logic [PERIOD_W-1:0] period_r;
  logic [VOL_W-1:0]    volume_r;

  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic                fb_r, fb_nxt;
  logic [PERIOD_W-1:0] timer_r, timer_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [VOL_W-1:0]    env_r, env_nxt;
  logic [VOL_W-1:0]    div_r, div_nxt;
  logic                start_r, start_nxt;

  logic                out_valid_r;
  logic [VOL_W-1:0]    level_r;
  logic                active_r;

  logic                accept;
  logic [VOL_W-1:0]    amp;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    lfsr_nxt  = lfsr_r;
    fb_nxt    = fb_r;
    timer_nxt = timer_r;
    len_nxt   = len_r;
    env_nxt   = env_r;
    div_nxt   = div_r;
    start_nxt = start_r;
    unique case (action_t'(in_action))
      ACT_TICK: begin
        if (len_r != '0) begin
          if (timer_r != '0) begin
            timer_nxt = timer_r - PERIOD_W'(1);
          end else begin
            timer_nxt = period_r;
            fb_nxt    = lfsr_r[0] ^ (short_mode_r ? lfsr_r[6] : lfsr_r[1]);
            lfsr_nxt  = {fb_nxt, lfsr_r[LFSR_W-1:1]};
          end
        end
      end
      ACT_QUARTER, ACT_HALF: begin
        if (start_r) begin
          start_nxt = 1'b0;
          div_nxt   = volume_r;
          env_nxt   = ENV_TOP;
        end else if (div_r == '0) begin
          div_nxt = volume_r;
          if (env_r != '0) begin
            env_nxt = env_r - VOL_W'(1);
          end else if (halt_loop_r) begin
            env_nxt = ENV_TOP;
          end
        end else begin
          div_nxt = div_r - VOL_W'(1);
        end
        if (action_t'(in_action) == ACT_HALF && len_r != '0 && !halt_loop_r) begin
          len_nxt = len_r - LEN_W'(1);
        end
      end
      ACT_START: begin
        len_nxt   = in_length_load;
        start_nxt = 1'b1;
      end
      ACT_DISABLE: begin
        len_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign amp = const_vol_r ? volume_r : env_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_mode_r <= 1'b0;
      period_r     <= '0;
      const_vol_r  <= 1'b0;
      volume_r     <= '0;
      halt_loop_r  <= 1'b0;
      lfsr_r       <= LFSR_RESET;
      fb_r         <= 1'b0;
      timer_r      <= '0;
      len_r        <= '0;
      env_r        <= '0;
      div_r        <= '0;
      start_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        lfsr_r  <= lfsr_nxt;
        fb_r    <= fb_nxt;
        timer_r <= timer_nxt;
        len_r   <= len_nxt;
        env_r   <= env_nxt;
        div_r   <= div_nxt;
        start_r <= start_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHORT_MODE: short_mode_r <= cfg_data[0];
          REG_PERIOD: begin
            period_r <= cfg_data[PERIOD_W-1:0];
            timer_r  <= cfg_data[PERIOD_W-1:0];
          end
          REG_CONST_VOL:  const_vol_r <= cfg_data[0];
          REG_VOLUME:     volume_r    <= cfg_data[VOL_W-1:0];
          REG_HALT_LOOP:  halt_loop_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      level_r  <= fb_nxt ? amp : '0;
      active_r <= (len_nxt != '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level         = level_r;
  assign out_length_active = active_r;

  `LNCE_ASSERT_NOW(a_hold_blocks_input, out_valid_r && out_stall, in_stall, "input taken while result held")
  `LNCE_ASSERT_NOW(a_silent_without_fb, out_valid_r && !fb_r, out_level == '0, "level nonzero with feedback low")
  `LNCE_ASSERT_NEXT(a_disable_clears, accept && in_action == ACT_DISABLE, out_valid && !out_length_active, "length active after disable")
  `LNCE_ASSERT_NEXT(a_start_loads, accept && in_action == ACT_START && in_length_load != '0, out_valid && out_length_active, "length idle after start")
  `LNCE_ASSERT_NEXT(a_tick_idle_lfsr, accept && in_action == ACT_TICK && len_r == '0, $stable(lfsr_r) && $stable(timer_r), "timer moved with zero length")

endmodule

FILE: tb/lfsr_noise_channel_with_envelope_test.sv
// ----------------------------------------------------------------------------
// Noise voice testbench
// Drives timer, frame, start, disable and unused-code words through the
// valid/stall channel with random gaps and stalls, predicts LFSR, envelope
// and length state in step, and checks every result word. Registers are
// rewritten between batches while the voice is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfsr_noise_channel_with_envelope_test;
  import lnce_pkg::*;

  localparam int unsigned TAP_LONG    = 1;
  localparam int unsigned TAP_SHORT   = 6;
  localparam int unsigned BATCHES     = 12;
  localparam int unsigned BATCH_WORDS = 56;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [LEN_W-1:0] load;
  } noise_word_t;

  typedef struct packed {
    logic [VOL_W-1:0] level;
    logic             active;
  } noise_out_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ACT_W-1:0] in_action = '0;
  logic [LEN_W-1:0] in_length_load = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VOL_W-1:0] out_level;
  logic             out_length_active;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // voice state as predicted
  logic [LFSR_W-1:0]   lfsr_m = LFSR_RESET;
  logic                fb_m = 1'b0;
  logic [PERIOD_W-1:0] tmr_m = '0;
  logic [LEN_W-1:0]    len_m = '0;
  logic [VOL_W-1:0]    env_level_m = '0;
  logic [VOL_W-1:0]    env_div_m = '0;
  logic                env_start_m = 1'b0;
  logic                short_m = 1'b0;
  logic [PERIOD_W-1:0] period_m = '0;
  logic                constvol_m = 1'b0;
  logic [VOL_W-1:0]    vol_m = '0;
  logic                halt_m = 1'b0;

  noise_word_t pending_q[$];
  noise_out_t  expected_q[$];

  bit          hold = 1'b1;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned results = 0;
  int unsigned shifts_seen = 0;
  int unsigned ticks = 0;
  int unsigned frames = 0;
  int unsigned starts = 0;
  int unsigned disables = 0;
  int unsigned unused = 0;
  int unsigned reg_writes = 0;
  int unsigned settings = 0;
  int unsigned pauses = 0;

  lfsr_noise_channel_with_envelope dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_length_load   (in_length_load),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level        (out_level),
    .out_length_active(out_length_active),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void clock_envelope();
    if (env_start_m) begin
      env_start_m = 1'b0;
      env_div_m   = vol_m;
      env_level_m = ENV_TOP;
    end else if (env_div_m == '0) begin
      env_div_m = vol_m;
      if (env_level_m != '0) env_level_m = env_level_m - 1'b1;
      else if (halt_m) env_level_m = ENV_TOP;
    end else begin
      env_div_m = env_div_m - 1'b1;
    end
  endfunction

  function automatic noise_out_t step_noise(input logic [ACT_W-1:0] act,
                                            input logic [LEN_W-1:0] load);
    noise_out_t       r;
    logic [VOL_W-1:0] amp;
    case (act)
      ACT_TICK: begin
        if (len_m != '0) begin
          if (tmr_m != '0) begin
            tmr_m = tmr_m - 1'b1;
          end else begin
            tmr_m  = period_m;
            fb_m   = lfsr_m[0] ^ (short_m ? lfsr_m[TAP_SHORT] : lfsr_m[TAP_LONG]);
            lfsr_m = {fb_m, lfsr_m[LFSR_W-1:1]};
            shifts_seen++;
          end
        end
      end
      ACT_QUARTER: clock_envelope();
      ACT_HALF: begin
        clock_envelope();
        if (len_m != '0 && !halt_m) len_m = len_m - 1'b1;
      end
      ACT_START: begin
        len_m       = load;
        env_start_m = 1'b1;
      end
      ACT_DISABLE: len_m = '0;
      default: ;
    endcase
    amp      = constvol_m ? vol_m : env_level_m;
    r.level  = fb_m ? amp : '0;
    r.active = (len_m != '0);
    return r;
  endfunction

  function automatic noise_word_t gen_word();
    noise_word_t w;
    int unsigned r;
    r      = $urandom_range(99);
    w.load = LEN_W'($urandom);
    if (r < 62) begin
      w.act = ACT_TICK;
    end else if (r < 72) begin
      w.act = ACT_QUARTER;
    end else if (r < 82) begin
      w.act = ACT_HALF;
    end else if (r < 90) begin
      w.act = ACT_START;
      if ($urandom_range(3) == 0) w.load = LEN_W'($urandom_range(4, 1));
    end else if (r < 94) begin
      w.act = ACT_DISABLE;
    end else begin
      w.act = ACT_W'($urandom_range(7, ACT_DISABLE + 1));
    end
    return w;
  endfunction

  task automatic queue_word(input logic [ACT_W-1:0] act, input logic [LEN_W-1:0] load);
    noise_word_t w;
    w.act  = act;
    w.load = load;
    pending_q.push_back(w);
  endtask

  // bits above the register width carry junk
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value,
                           input int unsigned width);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] data;
    mask = CFG_W'((1 << width) - 1);
    data = (CFG_W'($urandom) & ~mask) | (value & mask);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SHORT_MODE: short_m = data[0];
      REG_PERIOD: begin
        period_m = data[PERIOD_W-1:0];
        tmr_m    = period_m;
      end
      REG_CONST_VOL: constvol_m = data[0];
      REG_VOLUME:    vol_m = data[VOL_W-1:0];
      REG_HALT_LOOP: halt_m = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic sm, input logic [PERIOD_W-1:0] per, input logic cv,
                           input logic [VOL_W-1:0] vol, input logic halt);
    write_reg(REG_SHORT_MODE, CFG_W'(sm), 1);
    write_reg(REG_PERIOD, CFG_W'(per), PERIOD_W);
    write_reg(REG_CONST_VOL, CFG_W'(cv), 1);
    write_reg(REG_VOLUME, CFG_W'(vol), VOL_W);
    write_reg(REG_HALT_LOOP, CFG_W'(halt), 1);
    // unmapped index, must be ignored
    write_reg(IDX_W'($urandom_range(7, REG_HALT_LOOP + 1)), CFG_W'($urandom), CFG_W);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // releases the queued words, drains once midway, returns with the voice idle
  task automatic play_pending();
    int unsigned half_left;
    bit          paused;
    half_left = pending_q.size() / 2;
    paused    = 1'b0;
    @(negedge clk);
    hold = 1'b0;
    while (pending_q.size() != 0 || in_valid) begin
      @(negedge clk);
      if (!paused && pending_q.size() <= half_left) begin
        paused = 1'b1;
        hold   = 1'b1;
        while (in_valid || expected_q.size() != 0) @(negedge clk);
        hold = 1'b0;
        pauses++;
      end
    end
    hold = 1'b1;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_words
    noise_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_q.push_back(step_noise(in_action, in_length_load));
        case (in_action)
          ACT_TICK:                ticks++;
          ACT_QUARTER, ACT_HALF:   frames++;
          ACT_START:               starts++;
          ACT_DISABLE:             disables++;
          default:                 unused++;
        endcase
      end
      if (!hold && pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = pending_q.pop_front();
        in_valid       <= 1'b1;
        in_action      <= w.act;
        in_length_load <= w.load;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    noise_out_t exp_r;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, level %0d active %0b", $time, out_level,
                 out_length_active);
      end else begin
        exp_r = expected_q.pop_front();
        results++;
        if (out_level !== exp_r.level) begin
          errors++;
          $display("%0t: level expected %0d, got %0d", $time, exp_r.level, out_level);
        end
        if (out_length_active !== exp_r.active) begin
          errors++;
          $display("%0t: length_active expected %0b, got %0b", $time, exp_r.active,
                   out_length_active);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned b;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct  = 18;
    stall_pct = 86;

    configure(1'b0, '0, 1'b0, VOL_W'(2), 1'b0);
    queue_word(ACT_TICK, LEN_W'($urandom));
    queue_word(ACT_START, '1);
    repeat (4) queue_word(ACT_TICK, LEN_W'($urandom));
    repeat (4) queue_word(ACT_QUARTER, LEN_W'($urandom));
    repeat (2) queue_word(ACT_HALF, LEN_W'($urandom));
    queue_word(ACT_W'(5), LEN_W'($urandom));
    queue_word(ACT_W'(6), LEN_W'($urandom));
    queue_word(ACT_W'(7), LEN_W'($urandom));
    queue_word(ACT_DISABLE, LEN_W'($urandom));
    queue_word(ACT_TICK, LEN_W'($urandom));
    queue_word(ACT_START, LEN_W'(1));
    queue_word(ACT_HALF, LEN_W'($urandom));
    queue_word(ACT_TICK, LEN_W'($urandom));
    queue_word(ACT_START, '0);
    queue_word(ACT_QUARTER, LEN_W'($urandom));
    queue_word(ACT_START, LEN_W'(2));
    repeat (2) queue_word(ACT_TICK, LEN_W'($urandom));
    play_pending();

    for (b = 0; b < BATCHES; b++) begin
      if (b == BATCHES / 3) begin
        idle_pct  = 86;
        stall_pct = 18;
      end else if (b == 2 * BATCHES / 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      case (b)
        0: configure(1'b0, '0, 1'b0, '0, 1'b0);
        1: configure(1'b1, '1, 1'b1, '1, 1'b1);
        2: configure(1'b1, '0, 1'b0, VOL_W'(1), 1'b1);
        default: configure(1'($urandom),
                           ($urandom_range(3) == 0) ? PERIOD_W'($urandom)
                                                    : PERIOD_W'($urandom_range(6)),
                           1'($urandom), VOL_W'($urandom), 1'($urandom));
      endcase
      repeat (BATCH_WORDS) pending_q.push_back(gen_word());
      play_pending();
    end

    repeat (4) @(posedge clk);
    $display("Checked %0d result words: %0d ticks (%0d LFSR shifts), %0d frame clocks,",
             results, ticks, shifts_seen, frames);
    $display("%0d starts, %0d disables, %0d unused codes; %0d register settings, %0d drains.",
             starts, disables, unused, settings, pauses);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
